// ----- rtl/utf8_text_validator_macros.svh -----
// assertion macros used by the checker file utf8v_checker.sv
`ifndef UTF8_TEXT_VALIDATOR_MACROS_SVH
`define UTF8_TEXT_VALIDATOR_MACROS_SVH

// property checked on every clock edge outside of reset
`define UTF8V_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("utf8v assertion failed");

// property checked on every clock edge, reset included
`define UTF8V_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("utf8v assertion failed");

`endif

// ----- rtl/utf8v_pkg.sv -----
// types and constants of the utf8 text validator
package utf8v_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [12:0] len_t;
  typedef logic [20:0] cp_t;

  localparam byte_t ASCII_SPACE = 8'h20;
  localparam byte_t ASCII_DEL   = 8'h7f;

  localparam len_t LEN_CAP     = 13'd4096;
  localparam len_t COUNT_SAT   = 13'd4097;
  localparam len_t MAX_LEN_RST = 13'd255;

  localparam cp_t CP_MIN_2   = 21'h00080;
  localparam cp_t CP_MIN_3   = 21'h00800;
  localparam cp_t CP_MIN_4   = 21'h10000;
  localparam cp_t CP_MAX     = 21'h10ffff;
  localparam cp_t SURR_FIRST = 21'h0d800;
  localparam cp_t SURR_LAST  = 21'h0dfff;

  // continuation count of an open sequence
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TWO  = 2'd1;
  localparam logic [1:0] KIND_THREE = 2'd2;
  localparam logic [1:0] KIND_FOUR = 2'd3;

endpackage

// ----- rtl/utf8v_if.sv -----
// valid/ready channel interfaces of the utf8 text validator
interface utf8v_in_if;
  import utf8v_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  has_byte;
  logic  last;
  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface utf8v_out_if;
  import utf8v_pkg::*;
  logic valid;
  logic ready;
  logic valid_res;
  len_t length;
  modport source (output valid, valid_res, length, input ready);
  modport sink   (input valid, valid_res, length, output ready);
endinterface

interface utf8v_cfg_if;
  import utf8v_pkg::*;
  logic valid;
  logic ready;
  len_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/utf8_text_validator.sv -----
// utf8 text validator top level: byte decode, length count and verdict register
// the verdict is registered and shows in the cycle after the item that ends the string is taken
// throughput: one item per cycle, set by the single decode stage in front of the result register,
// as long as input ready is high; it drops only while a verdict waits and out_ready is low
// synchronous active-low reset clears string state and verdict valid, max_length returns to 255
module utf8_text_validator (
  input logic         clk,
  input logic         rst_n,
  utf8v_in_if.sink    in_ch,
  utf8v_out_if.source out_ch,
  utf8v_cfg_if.sink   cfg_ch
);
  import utf8v_pkg::*;

  // configuration
  len_t max_length_r;

  // string state
  logic [1:0] pend_r, pend_nxt;
  logic [1:0] kind_r, kind_nxt;
  cp_t        cp_r, cp_nxt;
  len_t       count_r, count_nxt;
  logic       failed_r, failed_nxt;

  // verdict register
  logic out_valid_r;
  logic valid_res_r, valid_res_nxt;
  len_t length_r;

  logic  in_acc;
  byte_t b;
  cp_t   cp_cont;
  len_t  limit;

  // a new item is taken as long as the verdict slot is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign b       = in_ch.data_byte;
  // code point with the continuation payload shifted in
  assign cp_cont = {cp_r[14:0], b[5:0]};
  // lengths beyond the cap act as the cap
  assign limit   = (max_length_r > LEN_CAP) ? LEN_CAP : max_length_r;

  always_comb begin
    pend_nxt   = pend_r;
    kind_nxt   = kind_r;
    cp_nxt     = cp_r;
    count_nxt  = count_r;
    failed_nxt = failed_r;
    if (in_ch.has_byte) begin
      if (count_r < COUNT_SAT) begin
        count_nxt = count_r + 13'd1;
      end
      // decoding stops once the string has failed, counting goes on
      if (!failed_r) begin
        if (pend_r == 2'd0) begin
          // lead byte or ascii
          priority if (!b[7]) begin
            if (b < ASCII_SPACE || b == ASCII_DEL) begin
              failed_nxt = 1'b1;
            end
          end else if (b[7:5] == 3'b110) begin
            kind_nxt = KIND_TWO;
            cp_nxt   = {16'd0, b[4:0]};
            pend_nxt = KIND_TWO;
          end else if (b[7:4] == 4'b1110) begin
            kind_nxt = KIND_THREE;
            cp_nxt   = {17'd0, b[3:0]};
            pend_nxt = KIND_THREE;
          end else if (b[7:3] == 5'b11110) begin
            kind_nxt = KIND_FOUR;
            cp_nxt   = {18'd0, b[2:0]};
            pend_nxt = KIND_FOUR;
          end else begin
            // stray continuation or invalid lead
            failed_nxt = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          // missing continuation
          failed_nxt = 1'b1;
          pend_nxt   = 2'd0;
        end else begin
          pend_nxt = pend_r - 2'd1;
          cp_nxt   = cp_cont;
          if (pend_r == 2'd1) begin
            // sequence complete: overlong, surrogate and range checks
            if ((kind_r == KIND_TWO && cp_cont < CP_MIN_2) ||
                (kind_r == KIND_THREE && cp_cont < CP_MIN_3) ||
                (kind_r == KIND_FOUR && cp_cont < CP_MIN_4) ||
                cp_cont > CP_MAX ||
                (cp_cont >= SURR_FIRST && cp_cont <= SURR_LAST)) begin
              failed_nxt = 1'b1;
            end
            kind_nxt = KIND_NONE;
            cp_nxt   = '0;
          end
        end
      end
    end
    // verdict from the state after this item
    valid_res_nxt = !failed_nxt && pend_nxt == 2'd0 &&
                    count_nxt != 13'd0 && count_nxt <= limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LEN_RST;
    end else if (cfg_ch.valid) begin
      max_length_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      kind_r   <= KIND_NONE;
      cp_r     <= '0;
      count_r  <= '0;
      failed_r <= 1'b0;
    end else if (in_acc) begin
      if (in_ch.last) begin
        // string done, start the next one clean
        pend_r   <= '0;
        kind_r   <= KIND_NONE;
        cp_r     <= '0;
        count_r  <= '0;
        failed_r <= 1'b0;
      end else begin
        pend_r   <= pend_nxt;
        kind_r   <= kind_nxt;
        cp_r     <= cp_nxt;
        count_r  <= count_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_ch.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last) begin
      valid_res_r <= valid_res_nxt;
      length_r    <= count_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.valid_res = valid_res_r;
  assign out_ch.length    = length_r;

endmodule

// ----- rtl/utf8v_checker.sv -----
// port-level assertions of the utf8 text validator and their bind
`include "utf8_text_validator_macros.svh"

module utf8v_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_valid_res,
  input utf8v_pkg::len_t     out_length
);
  import utf8v_pkg::*;

  // a waiting verdict holds until taken
  `UTF8V_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_valid_res) && $stable(out_length))

  // a string that ends produces a verdict next cycle
  `UTF8V_ASSERT(a_last_gives_result, clk, rst_n, in_valid && in_ready && in_last |=> out_valid)

  // a passing string is never empty nor longer than the cap
  `UTF8V_ASSERT(a_pass_length, clk, rst_n, out_valid && out_valid_res |-> out_length != 13'd0 && out_length <= LEN_CAP)

  // the reported count never runs past saturation
  `UTF8V_ASSERT(a_count_sat, clk, rst_n, out_valid |-> out_length <= COUNT_SAT)

  // no verdict shows right after a reset cycle
  `UTF8V_ASSERT_ALWAYS(a_reset_clear, clk, $past(!rst_n) |-> !out_valid)

endmodule

bind utf8_text_validator utf8v_checker u_utf8v_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_last       (in_ch.last),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_valid_res (out_ch.valid_res),
  .out_length    (out_ch.length)
);
